>>> rtl/dhoat_pkg.sv
// Package for the double-hash open-address table: widths, codes, item types,
// the controller state enum. No dependencies.
package dhoat_pkg;

   localparam int TableDepthDefault  = 64;
   localparam int MaxKeyBytesDefault = 8;
   localparam int ValueBitsDefault   = 32;

   localparam int PrimeA  = 131;
   localparam int PrimeB  = 137;
   localparam int StepAdd = 1;

   localparam logic [6:0] SizeReset = 7'd61;

   localparam logic [1:0] ACT_INSERT  = 2'd0;
   localparam logic [1:0] ACT_SEARCH  = 2'd1;
   localparam logic [1:0] ACT_DELETE  = 2'd2;
   localparam logic [1:0] ACT_UNKNOWN = 2'd3;

   localparam logic [2:0] ST_INSERTED = 3'd0;
   localparam logic [2:0] ST_UPDATED  = 3'd1;
   localparam logic [2:0] ST_FOUND    = 3'd2;
   localparam logic [2:0] ST_MISSING  = 3'd3;
   localparam logic [2:0] ST_DELETED  = 3'd4;
   localparam logic [2:0] ST_FULL     = 3'd5;

   localparam logic [1:0] MARK_EMPTY = 2'd0;
   localparam logic [1:0] MARK_LIVE  = 2'd1;
   localparam logic [1:0] MARK_TOMB  = 2'd2;

   typedef struct packed {
      logic [1:0]  action;
      logic [63:0] key_bytes;
      logic [3:0]  key_len;
      logic [31:0] value_in;
   } req_item_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] value_out;
      logic [5:0]  slot_index;
      logic [6:0]  entry_count;
   } rsp_item_type;

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_HASH, S_MOD, S_READ, S_CHECK, S_DONE
   } state_type;

endpackage

>>> rtl/dhoat_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module dhoat_ram #(
   parameter int Width = 8,
   parameter int Depth = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] addr,
   input  logic [Width-1:0]         wr_data,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

>>> rtl/double_hash_open_address_table.sv
// Key-value table with open addressing and double hashing. Each request
// (insert/update, search, delete) hashes its key byte by byte with primes
// 131 and 137 modulo the slot count, then probes slot (ha + a*(hb+1)) mod
// size; each probe is a memory read, then a check and write back. For each
// key byte, one step forms h*prime + byte, then S_MOD yields one remainder
// bit per cycle (14 bits for 64 slots). An unknown action skips hashing and
// probing. After reset a clearing pass over all TableDepth slots empties the
// slot marks before the first item is accepted. A finished result waits in
// the rsp register; the next item is accepted only once it has gone. Marks,
// keys and values live in one synchronous RAM; the live count is a register.
module double_hash_open_address_table
   import dhoat_pkg::*;
#(
   parameter int TableDepth  = TableDepthDefault,
   parameter int MaxKeyBytes = MaxKeyBytesDefault,
   parameter int ValueBits   = ValueBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_item,
   input  logic         csr_wr_en,
   input  logic [6:0]   csr_wr_data
);
   localparam int AW = $clog2(TableDepth);
   localparam int SW = AW + 1;
   localparam int LW = $clog2(MaxKeyBytes + 1);
   localparam int EW = 2 + 64 + 4 + ValueBits;
   localparam int TW = AW + 8;
   localparam int BW = $clog2(TW + 1);

   state_type state_ff, state_in;
   logic [6:0]    size_cfg_ff;
   logic [SW-1:0] size_ff, size_in;
   logic [SW-1:0] count_ff, count_in;
   logic [1:0]    act_ff, act_in;
   logic [63:0]   key_ff, key_in;
   logic [3:0]    len_ff, len_in;
   logic [ValueBits-1:0] val_ff, val_in;
   logic [LW-1:0] pos_ff, pos_in;
   logic [AW-1:0] ha_ff, ha_in, step_ff, step_in, idx_ff, idx_in;
   logic [SW-1:0] tries_ff, tries_in;
   logic [TW-1:0] ta_ff, ta_in, tb_ff, tb_in;
   logic [BW-1:0] bit_ff, bit_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_item_type  rsp_ff, rsp_in;

   logic          ram_we;
   logic [AW-1:0] ram_addr;
   logic [EW-1:0] ram_wdata, ram_rdata;

   dhoat_ram #(.Width(EW), .Depth(TableDepth)) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .addr   (ram_addr),
      .wr_data(ram_wdata),
      .rd_data(ram_rdata)
   );

   // Fields of the entry just read.
   logic [1:0]  rd_mark;
   logic [63:0] rd_key;
   logic [3:0]  rd_len;
   logic [ValueBits-1:0] rd_val;
   assign {rd_mark, rd_key, rd_len, rd_val} = ram_rdata;

   // Clamped size and masked key of the incoming item.
   logic [SW-1:0] size_use;
   logic [3:0]    len_use;
   logic [63:0]   key_use;
   always_comb begin
      if (size_cfg_ff < 7'd2) begin
         size_use = SW'(2);
      end else if (32'(size_cfg_ff) > TableDepth) begin
         size_use = SW'(TableDepth);
      end else begin
         size_use = SW'(size_cfg_ff);
      end
      len_use = (32'(req_item.key_len) > MaxKeyBytes) ? 4'(MaxKeyBytes)
                                                      : req_item.key_len;
      key_use = 64'(0);
      for (int b = 0; b < 8; b++) begin
         if (b < 32'(len_use)) begin
            key_use[8*b +: 8] = req_item.key_bytes[8*b +: 8];
         end
      end
   end

   // One Horner step per key byte: t = h*prime + c is formed in S_HASH, then
   // reduced mod size one bit per cycle in S_MOD (restoring remainder, MSB
   // first). The running remainder lives in ha/step and stays below size.
   logic [7:0]    hash_byte;
   logic [SW-1:0] ra_dbl, rb_dbl;
   logic [AW-1:0] ha_red, hb_red;
   assign hash_byte = key_ff[8*(32'(len_ff) - 1 - 32'(pos_ff)) +: 8];
   assign ra_dbl    = {ha_ff, ta_ff[TW-1]};
   assign rb_dbl    = {step_ff, tb_ff[TW-1]};
   assign ha_red    = (ra_dbl >= size_ff) ? AW'(ra_dbl - size_ff) : AW'(ra_dbl);
   assign hb_red    = (rb_dbl >= size_ff) ? AW'(rb_dbl - size_ff) : AW'(rb_dbl);

   // Next probe index: idx + step mod size, step = hb+1 <= size.
   logic [SW:0]   idx_sum;
   logic [AW-1:0] idx_next;
   assign idx_sum  = (SW+1)'(idx_ff) + (SW+1)'(step_ff);
   assign idx_next = (idx_sum >= (SW+1)'(size_ff)) ? AW'(idx_sum - (SW+1)'(size_ff))
                                                   : AW'(idx_sum);

   logic same;
   assign same = (rd_mark == MARK_LIVE) && (rd_len == len_ff) && (rd_key == key_ff);

   logic out_free;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: if (32'(idx_ff) == TableDepth - 1) state_in = S_IDLE;
         S_IDLE:  if (req_valid && !rsp_valid_ff) begin
            state_in = (req_item.action == ACT_UNKNOWN) ? S_DONE
                     : (len_use == 4'd0) ? S_READ : S_HASH;
         end
         S_HASH:  state_in = S_MOD;
         S_MOD:   if (bit_ff == BW'(1)) begin
            state_in = (32'(pos_ff) == 32'(len_ff) - 1) ? S_READ : S_HASH;
         end
         S_READ:  state_in = S_CHECK;
         S_CHECK: begin
            if (act_ff == ACT_INSERT) begin
               state_in = (rd_mark != MARK_LIVE || same || tries_ff == SW'(1))
                        ? S_DONE : S_READ;
            end else begin
               state_in = (rd_mark == MARK_EMPTY || same || tries_ff == SW'(1))
                        ? S_DONE : S_READ;
            end
         end
         S_DONE:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      size_in = size_ff; count_in = count_ff; act_in = act_ff; key_in = key_ff;
      len_in = len_ff; val_in = val_ff; pos_in = pos_ff; ha_in = ha_ff;
      step_in = step_ff; idx_in = idx_ff; tries_in = tries_ff;
      ta_in = ta_ff; tb_in = tb_ff; bit_in = bit_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_we = 1'b0; ram_addr = idx_ff; ram_wdata = ram_rdata;
      case (state_ff)
         S_CLEAR: begin
            ram_we = 1'b1;
            ram_wdata = EW'(0);
            idx_in = idx_ff + AW'(1);
         end
         S_IDLE: begin
            act_in = req_item.action; key_in = key_use; len_in = len_use;
            val_in = req_item.value_in[ValueBits-1:0];
            size_in = size_use; pos_in = '0; ha_in = '0; step_in = '0;
            rsp_in.status = ST_MISSING; rsp_in.value_out = '0;
            rsp_in.slot_index = '0; rsp_in.entry_count = 7'(count_ff);
         end
         S_HASH: begin
            ta_in = TW'(ha_ff) * TW'(PrimeA) + TW'(hash_byte);
            tb_in = TW'(step_ff) * TW'(PrimeB) + TW'(hash_byte);
            ha_in = '0; step_in = '0; bit_in = BW'(TW);
         end
         S_MOD: begin
            ha_in = ha_red; step_in = hb_red;
            ta_in = {ta_ff[TW-2:0], 1'b0};
            tb_in = {tb_ff[TW-2:0], 1'b0};
            bit_in = bit_ff - BW'(1);
            if (bit_ff == BW'(1)) pos_in = pos_ff + LW'(1);
         end
         S_READ: begin
            ram_addr = idx_ff;
         end
         S_CHECK: begin
            tries_in = tries_ff - SW'(1);
            idx_in = idx_next;
            if (act_ff == ACT_INSERT) begin
               if (rd_mark != MARK_LIVE) begin
                  ram_we = 1'b1;
                  ram_wdata = {MARK_LIVE, key_ff, len_ff, val_ff};
                  count_in = count_ff + SW'(1);
                  rsp_in.status = ST_INSERTED; rsp_in.slot_index = 6'(idx_ff);
                  rsp_in.entry_count = 7'(count_ff + SW'(1));
               end else if (same) begin
                  ram_we = 1'b1;
                  ram_wdata = {rd_mark, rd_key, rd_len, val_ff};
                  rsp_in.status = ST_UPDATED; rsp_in.slot_index = 6'(idx_ff);
               end else begin
                  rsp_in.status = ST_FULL;
               end
            end else if (same) begin
               rsp_in.slot_index = 6'(idx_ff);
               if (act_ff == ACT_SEARCH) begin
                  rsp_in.status = ST_FOUND;
                  rsp_in.value_out = 32'(rd_val);
               end else begin
                  ram_we = 1'b1;
                  ram_wdata = {MARK_TOMB, rd_key, rd_len, rd_val};
                  count_in = (count_ff != '0) ? count_ff - SW'(1) : count_ff;
                  rsp_in.status = ST_DELETED;
                  rsp_in.entry_count = 7'((count_ff != '0) ? count_ff - SW'(1) : count_ff);
               end
            end
         end
         S_DONE: rsp_valid_in = 1'b1;
         default: ;
      endcase
      // Start of probing: first index is ha, step hb+1, size tries.
      if (state_ff != S_READ && state_ff != S_CHECK && state_in == S_READ) begin
         idx_in   = (state_ff == S_MOD) ? ha_red : AW'(0);
         step_in  = ((state_ff == S_MOD) ? hb_red : AW'(0)) + AW'(StepAdd);
         tries_in = (state_ff == S_MOD) ? size_ff : size_use;
         if (state_ff == S_IDLE) size_in = size_use;
      end
      if (state_ff == S_READ) ram_addr = idx_ff;
   end

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR; size_cfg_ff <= SizeReset; count_ff <= '0;
         rsp_valid_ff <= 1'b0; idx_ff <= '0; tries_ff <= '0;
      end else begin
         state_ff <= state_in; count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in; idx_ff <= idx_in; tries_ff <= tries_in;
         if (csr_wr_en) size_cfg_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      size_ff <= size_in; act_ff <= act_in; key_ff <= key_in; len_ff <= len_in;
      val_ff <= val_in; pos_ff <= pos_in; ha_ff <= ha_in; step_ff <= step_in;
      ta_ff <= ta_in; tb_ff <= tb_in; bit_ff <= bit_in;
      if (out_free) rsp_ff <= rsp_in;
   end
endmodule

>>> dv/double_hash_open_address_table_tb.sv
// Self-checking testbench for double_hash_open_address_table: directed table, then random
// insert/search/delete traffic on small key sets, checked against a behavioral table model.
// Depends on dhoat_pkg and the RTL top level only.
module double_hash_open_address_table_tb
   import dhoat_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int Depth = 64;
   localparam int CycleLimit = 1500000;

   logic         clock;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_item_type req_item;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_item_type rsp_item;
   logic         csr_wr_en;
   logic [6:0]   csr_wr_data;

   double_hash_open_address_table i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_item(req_item),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_item(rsp_item),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // behavioral copy of the table
   logic [1:0]  mdl_mark [Depth];
   logic [63:0] mdl_key  [Depth];
   logic [3:0]  mdl_len  [Depth];
   logic [31:0] mdl_val  [Depth];
   logic [6:0]  mdl_count;
   logic [6:0]  mdl_size;

   rsp_item_type expected_rsps[$];
   int  mismatches;
   int  rsp_seen;
   int  cfg_writes;
   longint unsigned cycle_count;
   bit  long_hold;     // request a long receiver hold-off
   bit  rx_enable;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout at cycle %0d", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic logic [6:0] hash_key(logic [63:0] key, logic [3:0] len, int prime,
                                           int size);
      int h;
      h = 0;
      for (int i = 0; i < len; i++)
         h = (h * prime + ((key >> (8 * (len - 1 - i))) & 64'hFF)) % size;
      return h[6:0];
   endfunction

   // compute one response and update the model table
   function automatic rsp_item_type table_lookup(req_item_type req);
      rsp_item_type r;
      logic [3:0]  len;
      logic [63:0] key;
      int size, ha, hb, idx;
      bit same;
      len = (req.key_len > 4'd8) ? 4'd8 : req.key_len;
      key = (len == 4'd8) ? req.key_bytes : req.key_bytes & ((64'd1 << (8 * len)) - 64'd1);
      r = '0;
      r.status = ST_MISSING;
      if (req.action == ACT_UNKNOWN) begin
         r.entry_count = mdl_count;
         return r;
      end
      size = (mdl_size < 2) ? 2 : (mdl_size > Depth) ? Depth : mdl_size;
      ha = hash_key(key, len, PrimeA, size);
      hb = hash_key(key, len, PrimeB, size);
      if (req.action == ACT_INSERT) r.status = ST_FULL;
      for (int a = 0; a < size; a++) begin
         idx = (ha + a * (hb + StepAdd)) % size;
         same = mdl_mark[idx] == MARK_LIVE && mdl_len[idx] == len && mdl_key[idx] == key;
         if (req.action == ACT_INSERT) begin
            if (mdl_mark[idx] != MARK_LIVE) begin
               mdl_mark[idx] = MARK_LIVE;
               mdl_key[idx] = key;
               mdl_len[idx] = len;
               mdl_val[idx] = req.value_in;
               mdl_count++;
               r.status = ST_INSERTED;
               r.slot_index = idx[5:0];
               break;
            end
            if (same) begin
               mdl_val[idx] = req.value_in;
               r.status = ST_UPDATED;
               r.slot_index = idx[5:0];
               break;
            end
         end else begin
            if (mdl_mark[idx] == MARK_EMPTY) break;
            if (same) begin
               r.slot_index = idx[5:0];
               if (req.action == ACT_SEARCH) begin
                  r.status = ST_FOUND;
                  r.value_out = mdl_val[idx];
               end else begin
                  mdl_mark[idx] = MARK_TOMB;
                  if (mdl_count > 0) mdl_count--;
                  r.status = ST_DELETED;
               end
               break;
            end
         end
      end
      r.entry_count = mdl_count;
      return r;
   endfunction

   task automatic report_mismatch(string field, int got, int want);
      mismatches++;
      $display("mismatch on response %0d: %s got %0d expected %0d", rsp_seen, field, got, want);
   endtask

   // response side: random stalls, plus one long hold-off on request
   initial begin
      int wait_cycles;
      int hold_cycles;
      rsp_stall <= 1'b1;
      @(posedge clock iff !reset);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            hold_cycles = 0;
            while (hold_cycles < 400) begin
               @(posedge clock);
               hold_cycles++;
            end
            long_hold = 1'b0;
         end
         wait_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
         if (wait_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock iff rsp_valid);
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (expected_rsps.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = expected_rsps.pop_front();
            if (rsp_item.status !== want.status)
               report_mismatch("status", rsp_item.status, want.status);
            if (rsp_item.value_out !== want.value_out)
               report_mismatch("value_out", rsp_item.value_out, want.value_out);
            if (rsp_item.slot_index !== want.slot_index)
               report_mismatch("slot_index", rsp_item.slot_index, want.slot_index);
            if (rsp_item.entry_count !== want.entry_count)
               report_mismatch("entry_count", rsp_item.entry_count, want.entry_count);
         end
      end
   end

   // send one item, predicting at acceptance; no gap when back-to-back is drawn
   task automatic send_item(req_item_type req, int gap);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_item  <= req;
      req_valid <= 1'b1;
      @(posedge clock iff !req_stall);
      expected_rsps.push_back(table_lookup(req));
   endtask

   task automatic drain_and_idle();
      req_valid <= 1'b0;
      while (expected_rsps.size() != 0) @(posedge clock);
      // idle a while before the next phase
      repeat (150) @(posedge clock);
   endtask

   task automatic write_size(logic [6:0] size);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      mdl_size = size;
      cfg_writes++;
   endtask

   // build a key from a small pool so that collisions and repeats are common
   function automatic req_item_type random_req(int pool);
      req_item_type r;
      r.action     = ($urandom_range(0, 30) == 0) ? ACT_UNKNOWN : 2'($urandom_range(0, 2));
      r.key_len    = ($urandom_range(0, 15) == 0) ? 4'($urandom_range(9, 15))
                                                  : 4'($urandom_range(0, 3));
      r.key_bytes  = {$urandom(), $urandom()};
      if (r.key_len <= 4'd3)
         r.key_bytes[23:0] = 24'($urandom_range(0, pool)) * 24'h010305;
      r.value_in   = $urandom();
      return r;
   endfunction

   typedef struct {
      req_item_type req;
      bit           typed;
      rsp_item_type want;
   } directed_row_type;

   directed_row_type directed_rows[$];

   function automatic directed_row_type mk(logic [1:0] act, logic [63:0] key, logic [3:0] len,
                                           logic [31:0] val, bit typed, logic [2:0] st,
                                           logic [31:0] vo, logic [5:0] slot,
                                           logic [6:0] cnt);
      directed_row_type d;
      d.req   = '{action: act, key_bytes: key, key_len: len, value_in: val};
      d.typed = typed;
      d.want  = '{status: st, value_out: vo, slot_index: slot, entry_count: cnt};
      return d;
   endfunction

   initial begin
      rsp_item_type got_pred;
      int n_random;
      int sizes[8];
      mismatches = 0;
      rsp_seen = 0;
      cfg_writes = 0;
      long_hold = 1'b0;
      sizes = '{2, 3, 64, 7, 127, 0, 13, 61};
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_item <= '0;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      for (int i = 0; i < Depth; i++) begin
         mdl_mark[i] = MARK_EMPTY;
         mdl_key[i] = '0;
         mdl_len[i] = '0;
         mdl_val[i] = '0;
      end
      mdl_count = '0;
      mdl_size = SizeReset;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed part at reset size: empty-key rows read off at a glance
      directed_rows.push_back(mk(ACT_SEARCH, '1, 4'd0, 0, 1, ST_MISSING, 0, 0, 0));
      directed_rows.push_back(mk(ACT_DELETE, '0, 4'd0, 0, 1, ST_MISSING, 0, 0, 0));
      directed_rows.push_back(mk(ACT_INSERT, '1, 4'd0, '1, 1, ST_INSERTED, 0, 0, 1));
      directed_rows.push_back(mk(ACT_SEARCH, '0, 4'd0, 0, 1, ST_FOUND, '1, 0, 1));
      directed_rows.push_back(mk(ACT_INSERT, '0, 4'd0, 32'h5, 1, ST_UPDATED, 0, 0, 1));
      directed_rows.push_back(mk(ACT_UNKNOWN, '1, 4'd8, '1, 1, ST_MISSING, 0, 0, 1));
      directed_rows.push_back(mk(ACT_DELETE, '0, 4'd0, 0, 1, ST_DELETED, 0, 0, 0));
      directed_rows.push_back(mk(ACT_SEARCH, '0, 4'd0, 0, 1, ST_MISSING, 0, 0, 0));
      // extremes of key and length, predicted
      directed_rows.push_back(mk(ACT_INSERT, '1, 4'd8, '1, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_SEARCH, '1, 4'd15, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_INSERT, 64'hFFFF_FFFF_FFFF_FF41, 4'd1, 7, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_SEARCH, 64'h41, 4'd1, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_INSERT, 64'h4142, 4'd2, 9, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_DELETE, 64'h41, 4'd1, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_SEARCH, 64'h4142, 4'd2, 0, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_INSERT, 64'h41, 4'd1, 3, 0, 0, 0, 0, 0));
      directed_rows.push_back(mk(ACT_DELETE, '1, 4'd8, 0, 0, 0, 0, 0, 0));

      foreach (directed_rows[i]) begin
         send_item(directed_rows[i].req, $urandom_range(0, 17));
         got_pred = expected_rsps[$];
         if (directed_rows[i].typed && got_pred !== directed_rows[i].want)
            report_mismatch("directed row prediction", i, 0);
      end
      drain_and_idle();

      // random phases across table sizes, extremes included; small tables fill up
      foreach (sizes[p]) begin
         write_size(7'(sizes[p]));
         n_random = (sizes[p] >= 61 || sizes[p] == 127) ? 70 : 40;
         if (p == 4) long_hold = 1'b1;   // fill the block while the receiver holds
         for (int i = 0; i < n_random; i++)
            send_item(random_req(sizes[p] < 8 ? 6 : 40),
                      ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(0, 17));
         drain_and_idle();
      end

      $display("covered %0d responses over %0d size settings, with table-full, tombstone",
               rsp_seen, cfg_writes);
      $display("and reuse cases and a long receiver hold-off");
      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end
endmodule
